@@ src/hfmr_pkg.sv @@
// ----------------------------------------------------------------------------
// hfmr_pkg
// Shared types, result codes and the hex digit decode for the hex framed
// message receiver.
// ----------------------------------------------------------------------------
package hfmr_pkg;

	// default configuration
	localparam int        BUFFER_SIZE_DEF  = 128;
	localparam logic [7:0] START_MARKER_RST = 8'h41;

	// width of the run position field
	localparam int IDX_W = 6;

	// result codes
	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_DATA    = 3'd1,
		KIND_BAD_SUM = 3'd2,
		KIND_BAD_LEN = 3'd3,
		KIND_NO_DATA = 3'd4
	} kind_t;

	// controller states
	typedef enum logic [2:0] {
		S_HUNT,
		S_LEN_HI,
		S_LEN_LO,
		S_BODY,
		S_CHECK,
		S_RUN
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic  clear;
		logic  store;
		logic  sum_always;
		logic  take_len;
		logic  run_start;
		logic  load;
		kind_t load_kind;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic marker_hit;
		logic len_ok;
		logic body_done;
		logic sum_match;
		logic short_msg;
		logic run_last;
		logic out_free;
	} sts_t;

	// hex character to nibble, anything that is not a hex digit gives zero
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		case (c) inside
			[8'h30:8'h39]:                nibble_of = c[3:0];
			[8'h41:8'h46], [8'h61:8'h66]: nibble_of = c[3:0] + 4'd9;
			default:                      nibble_of = 4'd0;
		endcase
	endfunction

endpackage

@@ src/hex_framed_message_receiver.sv @@
// ----------------------------------------------------------------------------
// hex_framed_message_receiver
// Receives hex framed messages one character per item, checks the checksum
// and delivers the decoded payload as a run of bytes.
// ----------------------------------------------------------------------------
// Each character is taken while the result slot is free, so a frame is
// received at one character per cycle. The check character of a good frame
// with data bytes starts a run that holds off input and delivers one
// decoded byte per cycle while the result slot is free, read from the
// registered read port of the pair store, which holds BUFFER_SIZE+1
// characters as (BUFFER_SIZE+1)/2 decoded pairs. Rejects, mismatches and
// short messages give a single result. The store needs no clearing pass
// after reset. The start marker may be written only while the block is idle.
module hex_framed_message_receiver #(
	parameter int BUFFER_SIZE = hfmr_pkg::BUFFER_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [7:0]                  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  rx_char,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  kind,
	output logic [7:0]                  message_id,
	output logic [7:0]                  data_byte,
	output logic [hfmr_pkg::IDX_W-1:0]  byte_index,
	output logic                        last
);

	hfmr_pkg::cmd_t cmd;
	hfmr_pkg::sts_t sts;

	// frame controller
	hfmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath with pair store and result register
	hfmr_dpath #(
		.BUFFER_SIZE (BUFFER_SIZE)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.rx_char    (rx_char),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.kind       (kind),
		.message_id (message_id),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.last       (last)
	);

endmodule

@@ src/hfmr_ram.sv @@
// ----------------------------------------------------------------------------
// hfmr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hfmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/hfmr_dpath.sv @@
// ----------------------------------------------------------------------------
// hfmr_dpath
// Datapath of the receiver: character counter, running checksum, decoded
// pair store, run position counter and the result register.
// ----------------------------------------------------------------------------
module hfmr_dpath #(
	parameter int BUFFER_SIZE = hfmr_pkg::BUFFER_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [7:0]                  cfg_data,
	input  logic [7:0]                  rx_char,
	input  hfmr_pkg::cmd_t              cmd,
	output hfmr_pkg::sts_t              sts,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [2:0]                  kind,
	output logic [7:0]                  message_id,
	output logic [7:0]                  data_byte,
	output logic [hfmr_pkg::IDX_W-1:0]  byte_index,
	output logic                        last
);

	localparam int CNT_W      = $clog2(BUFFER_SIZE + 2);
	localparam int K_W        = CNT_W - 1;
	localparam int PAIR_DEPTH = (BUFFER_SIZE + 1) / 2;
	localparam int AW         = $clog2(PAIR_DEPTH);

	logic [7:0]       marker_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_new;
	logic [7:0]       len_q;
	logic [7:0]       sum_q;
	logic [3:0]       nib0_q;
	logic [3:0]       nib1_q;
	logic [3:0]       nib_in;
	logic [7:0]       pair_byte;
	logic [7:0]       raw1_q;
	logic [7:0]       id_q;
	logic [K_W-1:0]   k_q;
	logic [K_W-1:0]   k_inc;
	logic [K_W-1:0]   pairs;
	logic             sum_add;
	logic             run_last;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [7:0]       ram_rdata;

	logic                        out_valid_q;
	hfmr_pkg::kind_t             out_kind_q;
	logic [7:0]                  out_id_q;
	logic [7:0]                  out_data_q;
	logic [hfmr_pkg::IDX_W-1:0]  out_idx_q;
	logic                        out_last_q;
	logic [7:0]                  id_sel;
	logic [7:0]                  data_sel;
	logic [hfmr_pkg::IDX_W-1:0]  idx_sel;
	logic                        last_sel;
	logic                        out_free;

	// decode of the incoming character and the pair it completes
	assign nib_in    = hfmr_pkg::nibble_of(rx_char);
	assign pair_byte = {nib0_q, nib_in};
	assign count_new = count_q + CNT_W'(1);
	assign pairs     = count_q[CNT_W-1:1];
	assign k_inc     = k_q + K_W'(1);
	assign run_last  = (k_inc == pairs);
	assign sum_add   = cmd.sum_always || (9'(count_new) <= 9'(len_q));
	assign out_free  = !out_valid_q || out_ready;

	// status towards the controller
	always_comb begin
		sts.marker_hit = (rx_char == marker_q);
		sts.len_ok     = (9'(pair_byte) < 9'(BUFFER_SIZE));
		sts.body_done  = (9'(count_new) >= (9'(len_q) + 9'd2));
		sts.sum_match  = (sum_q == {nib1_q, nib0_q});
		sts.short_msg  = (pairs <= K_W'(2));
		sts.run_last   = run_last;
		sts.out_free   = out_free;
	end

	// start marker register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= hfmr_pkg::START_MARKER_RST;
		end else if (cfg_we) begin
			marker_q <= cfg_data;
		end
	end

	// character counter, length and checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			len_q   <= '0;
			sum_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				sum_q   <= '0;
			end else if (cmd.store) begin
				count_q <= count_new;
				if (sum_add) begin
					sum_q <= sum_q + rx_char;
				end
			end
			if (cmd.take_len) begin
				len_q <= pair_byte;
			end
		end
	end

	// last two nibbles, raw second character and decoded id
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			nib0_q <= nib_in;
			nib1_q <= nib0_q;
			if (count_q == CNT_W'(1)) begin
				raw1_q <= rx_char;
			end
			if (count_q == CNT_W'(3)) begin
				id_q <= pair_byte;
			end
		end
	end

	// run position
	always_ff @(posedge clk) begin
		if (cmd.run_start) begin
			k_q <= K_W'(2);
		end else if (cmd.load && cmd.load_kind == hfmr_pkg::KIND_DATA) begin
			k_q <= k_inc;
		end
	end

	// decoded pair store, written as each odd position completes a pair
	assign ram_we    = cmd.store && count_q[0];
	assign ram_waddr = count_q[AW:1];
	assign ram_re    = cmd.run_start ||
	                   (cmd.load && cmd.load_kind == hfmr_pkg::KIND_DATA && !run_last);
	assign ram_raddr = cmd.run_start ? AW'(2) : k_inc[AW-1:0];

	hfmr_ram #(
		.WIDTH (8),
		.DEPTH (PAIR_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (pair_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result field selection
	always_comb begin
		id_sel   = 8'd0;
		data_sel = 8'd0;
		idx_sel  = '0;
		last_sel = 1'b1;
		case (cmd.load_kind)
			hfmr_pkg::KIND_DATA: begin
				id_sel   = id_q;
				data_sel = ram_rdata;
				idx_sel  = hfmr_pkg::IDX_W'(k_q - K_W'(2));
				last_sel = run_last;
			end
			hfmr_pkg::KIND_NO_DATA: begin
				id_sel = (pairs >= K_W'(2)) ? id_q : raw1_q;
			end
			default: begin
				id_sel = 8'd0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_kind_q <= cmd.load_kind;
			out_id_q   <= id_sel;
			out_data_q <= data_sel;
			out_idx_q  <= idx_sel;
			out_last_q <= last_sel;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = out_kind_q;
	assign message_id = out_id_q;
	assign data_byte  = out_data_q;
	assign byte_index = out_idx_q;
	assign last       = out_last_q;

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	// the counter never runs past the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BUFFER_SIZE + 1))
		else $error("character count beyond store depth");

	// store writes and run reads never meet in one cycle
	a_ram_ports: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("pair store written and read together");

endmodule

@@ src/hfmr_ctrl.sv @@
// ----------------------------------------------------------------------------
// hfmr_ctrl
// Frame controller: hunts for the start marker, walks through length, body
// and check, then drives the result run out of the pair store.
// ----------------------------------------------------------------------------
module hfmr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  hfmr_pkg::sts_t  sts,
	output hfmr_pkg::cmd_t  cmd
);

	hfmr_pkg::state_t state_q;
	hfmr_pkg::state_t state_d;
	logic             accept;

	// characters are taken in every state but the run, once the result slot is free
	assign in_ready = (state_q != hfmr_pkg::S_RUN) && sts.out_free;
	assign accept   = in_valid && in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hfmr_pkg::S_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hfmr_pkg::S_HUNT: begin
				if (accept && sts.marker_hit) state_d = hfmr_pkg::S_LEN_HI;
			end
			hfmr_pkg::S_LEN_HI: begin
				if (accept) state_d = hfmr_pkg::S_LEN_LO;
			end
			hfmr_pkg::S_LEN_LO: begin
				if (accept) state_d = sts.len_ok ? hfmr_pkg::S_BODY : hfmr_pkg::S_HUNT;
			end
			hfmr_pkg::S_BODY: begin
				if (accept && sts.body_done) state_d = hfmr_pkg::S_CHECK;
			end
			hfmr_pkg::S_CHECK: begin
				if (accept) begin
					state_d = (sts.sum_match && !sts.short_msg) ?
					          hfmr_pkg::S_RUN : hfmr_pkg::S_HUNT;
				end
			end
			hfmr_pkg::S_RUN: begin
				if (sts.out_free && sts.run_last) state_d = hfmr_pkg::S_HUNT;
			end
			default: begin
				state_d = hfmr_pkg::S_HUNT;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.load_kind = hfmr_pkg::KIND_NONE;
		case (state_q)
			hfmr_pkg::S_HUNT: begin
				cmd.clear = accept && sts.marker_hit;
			end
			hfmr_pkg::S_LEN_HI: begin
				cmd.store      = accept;
				cmd.sum_always = 1'b1;
			end
			hfmr_pkg::S_LEN_LO: begin
				cmd.store      = accept;
				cmd.sum_always = 1'b1;
				cmd.take_len   = accept;
				cmd.load       = accept && !sts.len_ok;
				cmd.load_kind  = hfmr_pkg::KIND_BAD_LEN;
			end
			hfmr_pkg::S_BODY: begin
				cmd.store = accept;
			end
			hfmr_pkg::S_CHECK: begin
				if (accept) begin
					if (!sts.sum_match) begin
						cmd.load      = 1'b1;
						cmd.load_kind = hfmr_pkg::KIND_BAD_SUM;
					end else if (sts.short_msg) begin
						cmd.load      = 1'b1;
						cmd.load_kind = hfmr_pkg::KIND_NO_DATA;
					end else begin
						cmd.run_start = 1'b1;
					end
				end
			end
			hfmr_pkg::S_RUN: begin
				cmd.load      = sts.out_free;
				cmd.load_kind = hfmr_pkg::KIND_DATA;
			end
			default: begin
				cmd.load_kind = hfmr_pkg::KIND_NONE;
			end
		endcase
	end

	// the run finishes on its last byte
	a_run_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hfmr_pkg::S_RUN && sts.out_free && sts.run_last)
		|=> state_q == hfmr_pkg::S_HUNT)
		else $error("run did not end after its last byte");

	// a run only begins from the check state
	a_run_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == hfmr_pkg::S_RUN) |-> $past(cmd.run_start))
		else $error("run entered without a start");

	// no character is taken while the result slot is held
	a_in_gate: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> sts.out_free)
		else $error("item taken while result slot busy");

endmodule

@@ verif/tb_hex_framed_message_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_framed_message_receiver
// Feeds characters into the hex framed message receiver, one item per
// handshake, and tracks every frame with a behavioural copy of the receiver
// kept in the bench. Each output item is compared field by field with the
// oldest awaited result. Directed frames come first, then random frames
// (mostly well formed, some spoilt, rejected or cut short) under four
// start marker settings and four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_hex_framed_message_receiver;

	localparam int STORE_N      = hfmr_pkg::BUFFER_SIZE_DEF + 1;
	localparam int MAX_RUN      = 62;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		hfmr_pkg::kind_t kind;
		logic [7:0]      id;
		logic [7:0]      data;
		logic [5:0]      idx;
		logic            last;
	} frame_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [7:0]                 cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [7:0]                 rx_char;
	logic                       out_valid;
	logic                       out_ready;
	logic [2:0]                 kind;
	logic [7:0]                 message_id;
	logic [7:0]                 data_byte;
	logic [hfmr_pkg::IDX_W-1:0] byte_index;
	logic                       last;

	// receiver state as tracked by the bench
	logic [7:0] rcv_marker;
	logic       rcv_active;
	logic [1:0] rcv_phase;
	logic [7:0] rcv_count;
	logic [7:0] rcv_len;
	logic [7:0] rcv_sum;
	logic [7:0] rcv_store [STORE_N];

	frame_result_t awaited_outputs[$];

	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned items_sent;
	int unsigned sender_gap_pct;
	int unsigned receiver_stall_pct;

	hex_framed_message_receiver u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_char    (rx_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.message_id (message_id),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.last       (last)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// ascii hex digit to value, other characters count as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= "0" && c <= "9")
			v = c - "0";
		else if (c >= "A" && c <= "F")
			v = c - "A" + 8'd10;
		else if (c >= "a" && c <= "f")
			v = c - "a" + 8'd10;
		return v[3:0];
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		logic [7:0] c;
		if (n < 4'd10)
			c = "0" + n;
		else
			c = (lower ? "a" : "A") + n - 8'd10;
		return c;
	endfunction

	function automatic logic [7:0] stored_at(input int unsigned pos);
		return (pos < STORE_N) ? rcv_store[pos] : 8'h00;
	endfunction

	function automatic logic [7:0] pair_at(input int unsigned pos);
		return {hex_value(stored_at(pos)), hex_value(stored_at(pos + 1))};
	endfunction

	function automatic void await_result(input hfmr_pkg::kind_t k, input logic [7:0] id,
			input logic [7:0] data, input logic [5:0] idx, input logic lst);
		frame_result_t r;
		r.kind = k;
		r.id   = id;
		r.data = data;
		r.idx  = idx;
		r.last = lst;
		awaited_outputs.push_back(r);
	endfunction

	function automatic void keep_char(input logic [7:0] c);
		if (rcv_count < STORE_N)
			rcv_store[rcv_count] = c;
		if (rcv_count != 8'hFF)
			rcv_count++;
	endfunction

	function automatic void reset_frame_tracker();
		rcv_marker = hfmr_pkg::START_MARKER_RST;
		rcv_active = 1'b0;
		rcv_phase  = 2'd0;
		rcv_count  = 8'd0;
		rcv_len    = 8'd0;
		rcv_sum    = 8'd0;
		foreach (rcv_store[i])
			rcv_store[i] = 8'h00;
	endfunction

	// one accepted character through the frame tracker, results queued
	function automatic void advance_frame_state(input logic [7:0] c);
		int unsigned cnt;
		int unsigned pairs;
		logic [7:0]  id;
		if (!rcv_active) begin
			if (c == rcv_marker) begin
				rcv_sum    = 8'd0;
				rcv_active = 1'b1;
				rcv_phase  = 2'd0;
				rcv_count  = 8'd0;
			end
			return;
		end
		case (rcv_phase)
			2'd0: begin
				keep_char(c);
				rcv_sum   = rcv_sum + c;
				rcv_phase = 2'd1;
			end
			2'd1: begin
				keep_char(c);
				rcv_sum = rcv_sum + c;
				rcv_len = pair_at(0);
				if (rcv_len < hfmr_pkg::BUFFER_SIZE_DEF) begin
					rcv_phase = 2'd2;
				end else begin
					// length too large, frame dropped
					rcv_phase  = 2'd0;
					rcv_active = 1'b0;
					await_result(hfmr_pkg::KIND_BAD_LEN, 8'h00, 8'h00, 6'd0, 1'b1);
				end
			end
			2'd2: begin
				keep_char(c);
				if (rcv_count <= rcv_len)
					rcv_sum = rcv_sum + c;
				if (int'(rcv_count) >= int'(rcv_len) + 2)
					rcv_phase = 2'd3;
			end
			default: begin
				// this character only triggers the check
				cnt        = rcv_count;
				rcv_active = 1'b0;
				if (cnt < 2 || rcv_sum != pair_at(cnt - 2)) begin
					rcv_phase = 2'd0;
					await_result(hfmr_pkg::KIND_BAD_SUM, 8'h00, 8'h00, 6'd0, 1'b1);
					return;
				end
				pairs = cnt / 2;
				// frames of fewer than two pairs carry the raw second character as id
				id = (pairs >= 2) ? pair_at(2) : stored_at(1);
				if (pairs <= 2) begin
					await_result(hfmr_pkg::KIND_NO_DATA, id, 8'h00, 6'd0, 1'b1);
					return;
				end
				for (int unsigned k = 2; k < pairs && k - 2 < MAX_RUN; k++)
					await_result(hfmr_pkg::KIND_DATA, id, pair_at(2 * k), 6'(k - 2),
						k + 1 == pairs);
			end
		endcase
	endfunction

	// result checking
	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_outputs.size() == 0) begin
				report_mismatch("output item with none awaited, kind", kind, 0);
			end else begin
				want = awaited_outputs.pop_front();
				if (kind !== want.kind)
					report_mismatch("kind", kind, want.kind);
				if (message_id !== want.id)
					report_mismatch("message_id", message_id, want.id);
				if (data_byte !== want.data)
					report_mismatch("data_byte", data_byte, want.data);
				if (byte_index !== want.idx)
					report_mismatch("byte_index", byte_index, want.idx);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_char  <= c;
		do
			@(posedge clk);
		while (!in_ready);
		advance_frame_state(c);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_chars(input logic [7:0] chars[$]);
		foreach (chars[i])
			send_char(chars[i]);
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_marker(input logic [7:0] value);
		cfg_we     <= 1'b1;
		cfg_data   <= value;
		rcv_marker = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// marker, length, body and checksum, then a trigger character
	task automatic send_good_frame(input int unsigned len, input bit spoil);
		logic [7:0] body[$];
		logic [7:0] flen;
		logic [7:0] sum;
		logic [7:0] c1;
		logic [7:0] c2;
		logic [3:0] lo;
		body = {};
		flen = len[7:0];
		if (len < 2) begin
			// checksum overlaps the second length character, first one non-hex
			c1   = (len == 1) ? "1" : "0";
			lo   = 4'($urandom);
			c2   = hex_char(lo, 1'($urandom));
			body = {8'({hex_value(c1), lo} - c1), c1, c2};
		end else begin
			body.push_back(hex_char(flen[7:4], 1'($urandom)));
			body.push_back(hex_char(flen[3:0], 1'($urandom)));
			for (int unsigned pos = 2; pos < len; pos++) begin
				if ($urandom_range(99) < 80)
					body.push_back(hex_char(4'($urandom), 1'($urandom)));
				else
					body.push_back(8'($urandom));
			end
			sum = 8'd0;
			for (int unsigned pos = 0; pos < len; pos++)
				sum = sum + body[pos];
			body.push_back(hex_char(sum[7:4], 1'($urandom)));
			body.push_back(hex_char(sum[3:0], 1'($urandom)));
		end
		if (spoil)
			body[body.size() - 1] =
				hex_char(hex_value(body[body.size() - 1]) ^ 4'h1, 1'($urandom));
		send_char(rcv_marker);
		send_chars(body);
		send_char(8'($urandom));
	endtask

	task automatic send_noise(input int unsigned n);
		logic [7:0] c;
		repeat (n) begin
			c = 8'($urandom);
			if (c == rcv_marker)
				c = c ^ 8'h01;
			send_char(c);
		end
	endtask

	task automatic run_random_frames(input int unsigned budget);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned len;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			send_noise($urandom_range(2));
			pick = $urandom_range(99);
			// mostly short frames, a few long ones and the largest
			len = $urandom_range(20);
			if ($urandom_range(99) < 4)
				len = hfmr_pkg::BUFFER_SIZE_DEF - 1;
			else if ($urandom_range(99) < 11)
				len = $urandom_range(hfmr_pkg::BUFFER_SIZE_DEF - 2, 21);
			if (pick < 70) begin
				send_good_frame(len, 1'b0);
			end else if (pick < 80) begin
				send_good_frame(len, 1'b1);
			end else if (pick < 88) begin
				// length at or beyond the store size
				send_char(rcv_marker);
				send_char(hex_char(4'($urandom_range(15, 8)), 1'($urandom)));
				send_char(hex_char(4'($urandom), 1'($urandom)));
			end else if (pick < 95) begin
				// cut short, then random characters until the frame closes
				send_char(rcv_marker);
				repeat ($urandom_range(5))
					send_char(8'($urandom));
				while (rcv_active)
					send_char(8'($urandom));
			end else begin
				send_noise($urandom_range(6, 1));
			end
		end
	endtask

	task automatic test_directed();
		sender_gap_pct     = 0;
		receiver_stall_pct = 0;
		// idle extremes, then a rejected length of all ones
		send_chars({8'h00, 8'hFF, hfmr_pkg::START_MARKER_RST, "f", "F"});
		// short frame with the id taken raw
		send_good_frame(1, 1'b0);
		// marker inside the body, checksum decoded as a data byte, marker as trigger
		send_chars({hfmr_pkg::START_MARKER_RST, "0", "4", hfmr_pkg::START_MARKER_RST,
			"b", "0", "7", hfmr_pkg::START_MARKER_RST});
		// checksum mismatch
		send_good_frame(2, 1'b1);
	endtask

	task automatic test_free_flow();
		wait_until_drained();
		write_marker(8'h00);
		sender_gap_pct     = 0;
		receiver_stall_pct = 0;
		run_random_frames(70);
	endtask

	task automatic test_sender_gaps();
		wait_until_drained();
		write_marker(8'hFF);
		sender_gap_pct     = 70;
		receiver_stall_pct = 0;
		run_random_frames(70);
	endtask

	task automatic test_receiver_stalls();
		wait_until_drained();
		write_marker(8'($urandom));
		sender_gap_pct     = 0;
		receiver_stall_pct = 70;
		run_random_frames(70);
	endtask

	task automatic test_both_sides_idle();
		wait_until_drained();
		write_marker(hfmr_pkg::START_MARKER_RST);
		sender_gap_pct     = 33;
		receiver_stall_pct = 33;
		run_random_frames(70);
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_data           = 8'h00;
		in_valid           = 1'b0;
		rx_char            = 8'h00;
		out_ready          = 1'b0;
		mismatch_count     = 0;
		cycle_count        = 0;
		items_sent         = 0;
		sender_gap_pct     = 0;
		receiver_stall_pct = 0;
		reset_frame_tracker();
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_free_flow();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_sides_idle();
		wait_until_drained();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
